[hw/rtl/cdi_pkg.sv]
// ----------------------------------------------------------------------------
// cdi_pkg: shared definitions for the calendar date incrementer
// Operation and status codes, year limits and the date record type.
// ----------------------------------------------------------------------------
package cdi_pkg;

	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int YEAR_W  = 12;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 3;
	localparam int DCNT_W  = 16;

	localparam int MIN_YEAR   = 1900;
	localparam int MAX_YEAR   = 2100;
	localparam int COUNT_BITS = 16;
	// Bits of the day count port that take part in an add.
	localparam int CNT_W = (COUNT_BITS < DCNT_W) ? COUNT_BITS : DCNT_W;

	localparam logic [YEAR_W-1:0]  TOP_YEAR   = YEAR_W'(4095);
	localparam logic [YEAR_W-1:0]  RESET_YEAR = YEAR_W'(1900);
	localparam logic [MONTH_W-1:0] LAST_MONTH = MONTH_W'(12);
	localparam logic [MONTH_W-1:0] FIRST_MON  = MONTH_W'(1);
	localparam logic [DAY_W-1:0]   FIRST_DAY  = DAY_W'(1);
	localparam logic [DAY_W-1:0]   LAST_DEC   = DAY_W'(31);

	// Operation codes
	localparam logic [OP_W-1:0] OP_SET  = 2'd0;
	localparam logic [OP_W-1:0] OP_INC  = 2'd1;
	localparam logic [OP_W-1:0] OP_PINC = 2'd2;
	localparam logic [OP_W-1:0] OP_ADD  = 2'd3;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_BAD_MONTH = 3'd1;
	localparam logic [STAT_W-1:0] ST_BAD_YEAR  = 3'd2;
	localparam logic [STAT_W-1:0] ST_BAD_DAY   = 3'd3;
	localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd4;

	typedef struct packed {
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [YEAR_W-1:0]  year;
	} date_t;

	// What the day unit reports about the date it is given.
	typedef struct packed {
		date_t            next;
		logic [DAY_W-1:0] mlen;
		logic             at_top;
	} dstep_t;

endpackage

[hw/rtl/calendar_date_incrementer_core.sv]
// ----------------------------------------------------------------------------
// calendar_date_incrementer_core: Gregorian date counter
// Holds a date and sets, increments or advances it by a count of days.
// ----------------------------------------------------------------------------
// One item is in flight at a time. For a set or a single-day increment the
// result beat is offered in the next cycle. An add of N days walks the
// shared day unit once per cycle (N is at most 65535) and offers its result
// when the count runs out, or stops early with an overflow status if the
// date reaches December 31 of 4095 first. An add of zero days answers as a
// set does. Input stall stays high from acceptance until the result beat
// has been taken.
module calendar_date_incrementer_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [cdi_pkg::OP_W-1:0]     op,
	input  logic [cdi_pkg::MONTH_W-1:0]  set_month,
	input  logic [cdi_pkg::DAY_W-1:0]    set_day,
	input  logic [cdi_pkg::YEAR_W-1:0]   set_year,
	input  logic [cdi_pkg::DCNT_W-1:0]   day_count,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [cdi_pkg::MONTH_W-1:0]  out_month,
	output logic [cdi_pkg::DAY_W-1:0]    out_day,
	output logic [cdi_pkg::YEAR_W-1:0]   out_year,
	output logic [cdi_pkg::STAT_W-1:0]   status
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]                      state_q;
	cdi_pkg::date_t                  cur_q;
	cdi_pkg::date_t                  res_q;
	logic [cdi_pkg::STAT_W-1:0]      stat_q;
	logic [cdi_pkg::CNT_W-1:0]       cnt_q;

	cdi_pkg::date_t                  set_date;
	cdi_pkg::date_t                  unit_in;
	cdi_pkg::dstep_t                 unit_out;
	logic                            month_ok;
	logic                            year_ok;
	logic                            day_ok;
	logic [cdi_pkg::STAT_W-1:0]      set_stat;
	logic [cdi_pkg::CNT_W-1:0]       cnt_in;
	logic                            take;

	assign set_date.month = set_month;
	assign set_date.day   = set_day;
	assign set_date.year  = set_year;
	assign cnt_in         = day_count[cdi_pkg::CNT_W-1:0];
	assign take           = in_valid && !in_stall;

	// The day unit checks the requested date during a set and steps the
	// stored date otherwise.
	assign unit_in = ((state_q == S_IDLE) && (op == cdi_pkg::OP_SET)) ? set_date : cur_q;

	cdi_day_unit u_day (
		.date (unit_in),
		.step (unit_out)
	);

	always_comb begin
		month_ok = set_month inside {[cdi_pkg::FIRST_MON:cdi_pkg::LAST_MONTH]};
		year_ok  = (set_year >= cdi_pkg::YEAR_W'(cdi_pkg::MIN_YEAR))
			&& (set_year <= cdi_pkg::YEAR_W'(cdi_pkg::MAX_YEAR));
		day_ok   = (set_day >= cdi_pkg::FIRST_DAY) && (set_day <= unit_out.mlen);
		if (!month_ok) begin
			set_stat = cdi_pkg::ST_BAD_MONTH;
		end else if (!year_ok) begin
			set_stat = cdi_pkg::ST_BAD_YEAR;
		end else if (!day_ok) begin
			set_stat = cdi_pkg::ST_BAD_DAY;
		end else begin
			set_stat = cdi_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_q.month <= cdi_pkg::FIRST_MON;
			cur_q.day   <= cdi_pkg::FIRST_DAY;
			cur_q.year  <= cdi_pkg::RESET_YEAR;
			res_q       <= '0;
			stat_q      <= cdi_pkg::ST_OK;
			cnt_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take) begin
						state_q <= S_DONE;
						case (op)
							cdi_pkg::OP_SET: begin
								stat_q <= set_stat;
								if (set_stat == cdi_pkg::ST_OK) begin
									cur_q <= set_date;
									res_q <= set_date;
								end else begin
									res_q <= cur_q;
								end
							end
							cdi_pkg::OP_INC, cdi_pkg::OP_PINC: begin
								stat_q <= unit_out.at_top ? cdi_pkg::ST_OVERFLOW : cdi_pkg::ST_OK;
								cur_q  <= unit_out.next;
								res_q  <= (op == cdi_pkg::OP_INC) ? unit_out.next : cur_q;
							end
							default: begin
								stat_q <= cdi_pkg::ST_OK;
								res_q  <= cur_q;
								cnt_q  <= cnt_in;
								if (cnt_in != '0) begin
									state_q <= S_RUN;
								end
							end
						endcase
					end
				end
				S_RUN: begin
					if (unit_out.at_top) begin
						// The remaining days are dropped at the top date.
						stat_q  <= cdi_pkg::ST_OVERFLOW;
						res_q   <= cur_q;
						state_q <= S_DONE;
					end else begin
						cur_q <= unit_out.next;
						cnt_q <= cnt_q - cdi_pkg::CNT_W'(1);
						if (cnt_q == cdi_pkg::CNT_W'(1)) begin
							stat_q  <= cdi_pkg::ST_OK;
							res_q   <= unit_out.next;
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_DONE);
	assign out_month = res_q.month;
	assign out_day   = res_q.day;
	assign out_year  = res_q.year;
	assign status    = stat_q;

	// An add in progress always has days left to walk.
	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (cnt_q != '0))
		else $error("add in progress with zero days left");

	// The stored date is always a legal month and day.
	a_cur_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q.month >= cdi_pkg::FIRST_MON) && (cur_q.month <= cdi_pkg::LAST_MONTH)
		&& (cur_q.day >= cdi_pkg::FIRST_DAY) && (cur_q.day <= cdi_pkg::LAST_DEC))
		else $error("stored date out of range");

	// An overflow report leaves the stored date at the top date.
	a_ovf_top: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == cdi_pkg::ST_OVERFLOW)) |->
		((cur_q.year == cdi_pkg::TOP_YEAR) && (cur_q.month == cdi_pkg::LAST_MONTH)
		&& (cur_q.day == cdi_pkg::LAST_DEC)))
		else $error("overflow reported below the top date");

	// A taken beat is followed by a result or by the walk of an add.
	a_take_next: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (out_valid || (state_q == S_RUN)))
		else $error("accepted beat produced no work");

endmodule

[hw/rtl/cdi_day_unit.sv]
// ----------------------------------------------------------------------------
// cdi_day_unit: month length and next-day logic
// Gives the month length of a date and the date one day later (held at the top date).
// ----------------------------------------------------------------------------
module cdi_day_unit (
	input  cdi_pkg::date_t  date,
	output cdi_pkg::dstep_t step
);

	// 3113 is the inverse of 25 modulo 4096: a year is a multiple of 25
	// exactly when year * 3113 mod 4096 does not exceed 4095 / 25.
	localparam logic [cdi_pkg::YEAR_W-1:0] INV25 = cdi_pkg::YEAR_W'(3113);
	localparam logic [cdi_pkg::YEAR_W-1:0] LIM25 = cdi_pkg::YEAR_W'(4095 / 25);

	logic [cdi_pkg::YEAR_W-1:0] m25;
	logic                       div25;
	logic                       leap;
	logic                       end_of_month;
	logic [cdi_pkg::DAY_W-1:0]  mlen;
	logic                       at_top;
	cdi_pkg::date_t             next_date;

	assign m25   = cdi_pkg::YEAR_W'(date.year * INV25);
	assign div25 = (m25 <= LIM25);
	assign leap  = (date.year[1:0] == 2'b00) && (!div25 || (date.year[3:0] == 4'h0));

	always_comb begin
		case (date.month)
			4'd2: mlen = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: mlen = 5'd30;
			default: mlen = 5'd31;
		endcase
	end

	assign end_of_month = (date.day >= mlen);
	assign at_top       = end_of_month && (date.month == cdi_pkg::LAST_MONTH)
		&& (date.year == cdi_pkg::TOP_YEAR);

	always_comb begin
		next_date = date;
		if (!end_of_month) begin
			next_date.day = date.day + cdi_pkg::FIRST_DAY;
		end else if (date.month < cdi_pkg::LAST_MONTH) begin
			next_date.month = date.month + cdi_pkg::FIRST_MON;
			next_date.day   = cdi_pkg::FIRST_DAY;
		end else if (!at_top) begin
			next_date.year  = date.year + cdi_pkg::YEAR_W'(1);
			next_date.month = cdi_pkg::FIRST_MON;
			next_date.day   = cdi_pkg::FIRST_DAY;
		end
	end

	assign step = {next_date, mlen, at_top};

endmodule

[bench/date_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_tracker: watches the date counter's channels and checks every result
// Keeps its own copy of the stored date, works out the report for each input
// beat it sees accepted, and compares each result beat with the oldest one.
// ----------------------------------------------------------------------------
module date_tracker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [cdi_pkg::OP_W-1:0]     op,
	input  logic [cdi_pkg::MONTH_W-1:0]  set_month,
	input  logic [cdi_pkg::DAY_W-1:0]    set_day,
	input  logic [cdi_pkg::YEAR_W-1:0]   set_year,
	input  logic [cdi_pkg::DCNT_W-1:0]   day_count,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [cdi_pkg::MONTH_W-1:0]  out_month,
	input  logic [cdi_pkg::DAY_W-1:0]    out_day,
	input  logic [cdi_pkg::YEAR_W-1:0]   out_year,
	input  logic [cdi_pkg::STAT_W-1:0]   status,
	output int                           fail_count,
	output int                           result_beats,
	output int                           overflow_beats,
	output int                           rejected_sets
);

	typedef struct packed {
		cdi_pkg::date_t             date;
		logic [cdi_pkg::STAT_W-1:0] code;
	} date_report_t;

	cdi_pkg::date_t cal;
	date_report_t   awaited[$];
	int             mismatches = 0;

	function automatic bit leap_year(input logic [cdi_pkg::YEAR_W-1:0] y);
		return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
	endfunction

	function automatic logic [cdi_pkg::DAY_W-1:0] days_in_month(
			input logic [cdi_pkg::MONTH_W-1:0] m, input logic [cdi_pkg::YEAR_W-1:0] y);
		case (m)
			4'd2: return leap_year(y) ? cdi_pkg::DAY_W'(29) : cdi_pkg::DAY_W'(28);
			4'd4, 4'd6, 4'd9, 4'd11: return cdi_pkg::DAY_W'(30);
			default: return cdi_pkg::DAY_W'(31);
		endcase
	endfunction

	// Moves the stored date on by one day. Returns 0 and leaves the date
	// alone when it already sits on the last day the year field can hold.
	function automatic bit roll_one_day();
		if (cal.day < days_in_month(cal.month, cal.year)) begin
			cal.day = cal.day + 1'b1;
		end else if (cal.month < cdi_pkg::LAST_MONTH) begin
			cal.month = cal.month + 1'b1;
			cal.day   = cdi_pkg::FIRST_DAY;
		end else if (cal.year >= cdi_pkg::TOP_YEAR) begin
			return 1'b0;
		end else begin
			cal.year  = cal.year + 1'b1;
			cal.month = cdi_pkg::FIRST_MON;
			cal.day   = cdi_pkg::FIRST_DAY;
		end
		return 1'b1;
	endfunction

	function automatic date_report_t date_after_beat(
			input logic [cdi_pkg::OP_W-1:0] code,
			input logic [cdi_pkg::MONTH_W-1:0] m, input logic [cdi_pkg::DAY_W-1:0] d,
			input logic [cdi_pkg::YEAR_W-1:0] y, input logic [cdi_pkg::DCNT_W-1:0] cnt);
		date_report_t   rep;
		cdi_pkg::date_t was;
		int unsigned    left;
		was      = cal;
		rep.code = cdi_pkg::ST_OK;
		case (code)
			cdi_pkg::OP_SET: begin
				// Month is checked first, then year, then day.
				if (m < cdi_pkg::FIRST_MON || m > cdi_pkg::LAST_MONTH)
					rep.code = cdi_pkg::ST_BAD_MONTH;
				else if (y < cdi_pkg::MIN_YEAR || y > cdi_pkg::MAX_YEAR)
					rep.code = cdi_pkg::ST_BAD_YEAR;
				else if (d < cdi_pkg::FIRST_DAY || d > days_in_month(m, y))
					rep.code = cdi_pkg::ST_BAD_DAY;
				else begin
					cal.month = m;
					cal.day   = d;
					cal.year  = y;
				end
				rep.date = cal;
			end
			cdi_pkg::OP_INC, cdi_pkg::OP_PINC: begin
				if (!roll_one_day())
					rep.code = cdi_pkg::ST_OVERFLOW;
				rep.date = (code == cdi_pkg::OP_INC) ? cal : was;
			end
			default: begin
				left = 32'(cnt[cdi_pkg::CNT_W-1:0]);
				while (left > 0 && rep.code == cdi_pkg::ST_OK) begin
					if (roll_one_day())
						left--;
					else
						rep.code = cdi_pkg::ST_OVERFLOW;
				end
				rep.date = cal;
			end
		endcase
		return rep;
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at result beat %0d, %0t: %s: got %0d, expected %0d",
			result_beats, $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		date_report_t want;
		if (!arst_n) begin
			cal.month = cdi_pkg::FIRST_MON;
			cal.day   = cdi_pkg::FIRST_DAY;
			cal.year  = cdi_pkg::RESET_YEAR;
			awaited.delete();
			fail_count     <= 0;
			result_beats   <= 0;
			overflow_beats <= 0;
			rejected_sets  <= 0;
		end else begin
			// Only one item is in flight, so the input side never sees a
			// result beat for the same item at the same edge.
			if (in_valid && !in_stall)
				awaited.push_back(date_after_beat(op, set_month, set_day, set_year,
					day_count));
			if (out_valid && !out_stall) begin
				result_beats <= result_beats + 1;
				if (awaited.size() == 0) begin
					flag_mismatch("result beat with nothing awaited", 0, 0);
				end else begin
					want = awaited.pop_front();
					if (out_month !== want.date.month)
						flag_mismatch("out_month", out_month, want.date.month);
					if (out_day !== want.date.day)
						flag_mismatch("out_day", out_day, want.date.day);
					if (out_year !== want.date.year)
						flag_mismatch("out_year", out_year, want.date.year);
					if (status !== want.code)
						flag_mismatch("status", status, want.code);
					if (want.code == cdi_pkg::ST_OVERFLOW)
						overflow_beats <= overflow_beats + 1;
					else if (want.code != cdi_pkg::ST_OK)
						rejected_sets <= rejected_sets + 1;
				end
			end
			// Reports still awaited count against the run; the top reads this
			// only once every result should have arrived.
			fail_count <= mismatches + awaited.size();
		end
	end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the calendar date counter
// Drives directed and random date beats with bursty input and a stalling
// receiver, and leaves prediction and comparison to date_tracker.
// ----------------------------------------------------------------------------
module testbench;

	localparam int RANDOM_ITEMS = 70;
	localparam int HOLD_AFTER   = 50;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 6000000;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        in_stall;
	logic [cdi_pkg::OP_W-1:0]    op        = cdi_pkg::OP_SET;
	logic [cdi_pkg::MONTH_W-1:0] set_month = '0;
	logic [cdi_pkg::DAY_W-1:0]   set_day   = '0;
	logic [cdi_pkg::YEAR_W-1:0]  set_year  = '0;
	logic [cdi_pkg::DCNT_W-1:0]  day_count = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [cdi_pkg::MONTH_W-1:0] out_month;
	logic [cdi_pkg::DAY_W-1:0]   out_day;
	logic [cdi_pkg::YEAR_W-1:0]  out_year;
	logic [cdi_pkg::STAT_W-1:0]  status;

	int fail_count;
	int result_beats;
	int overflow_beats;
	int rejected_sets;

	int sent_items  = 0;
	int burst_left  = 0;
	int cycle_count = 0;
	int hold_left   = 0;
	bit hold_done   = 1'b0;
	int stall_mode  = 0;
	int mode_left   = 0;

	always #4 clk = ~clk;

	calendar_date_incrementer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.set_month (set_month),
		.set_day   (set_day),
		.set_year  (set_year),
		.day_count (day_count),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_month (out_month),
		.out_day   (out_day),
		.out_year  (out_year),
		.status    (status)
	);

	date_tracker tracker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.set_month      (set_month),
		.set_day        (set_day),
		.set_year       (set_year),
		.day_count      (day_count),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_month      (out_month),
		.out_day        (out_day),
		.out_year       (out_year),
		.status         (status),
		.fail_count     (fail_count),
		.result_beats   (result_beats),
		.overflow_beats (overflow_beats),
		.rejected_sets  (rejected_sets)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d of %0d results in",
				cycle_count, result_beats, sent_items);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver: runs of no stall, light stall and heavy stall, plus one long
	// hold-off so the block sits full and stalls the sender.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && sent_items >= HOLD_AFTER) begin
			out_stall <= 1'b1;
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 2);
				mode_left  <= $urandom_range(5, 60);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// Offers one beat and returns at the edge that accepts it. Beats go out
	// in bursts with idle gaps between them.
	task automatic send_item(input logic [cdi_pkg::OP_W-1:0] code,
			input logic [cdi_pkg::MONTH_W-1:0] m, input logic [cdi_pkg::DAY_W-1:0] d,
			input logic [cdi_pkg::YEAR_W-1:0] y, input logic [cdi_pkg::DCNT_W-1:0] cnt);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid  <= 1'b1;
		op        <= code;
		set_month <= m;
		set_day   <= d;
		set_year  <= y;
		day_count <= cnt;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_items <= sent_items + 1;
	endtask

	initial begin
		logic [cdi_pkg::OP_W-1:0]    code;
		logic [cdi_pkg::MONTH_W-1:0] mon;
		logic [cdi_pkg::DAY_W-1:0]   dd;
		logic [cdi_pkg::YEAR_W-1:0]  yr;
		logic [cdi_pkg::DCNT_W-1:0]  cnt;
		int unsigned                 pick;
		int                          big_adds;
		big_adds = 3;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: range checks in their order, leap rules, both increments
		// across month and year ends, and the climb to the year-4095 ceiling.
		send_item(cdi_pkg::OP_INC, '0, '0, '0, '0);
		send_item(cdi_pkg::OP_SET, 4'd0, 5'd0, 12'd0, '0);
		send_item(cdi_pkg::OP_SET, 4'd15, 5'd31, 12'd4095, 16'hFFFF);
		send_item(cdi_pkg::OP_SET, 4'd6, 5'd15, 12'd1899, '0);
		send_item(cdi_pkg::OP_SET, 4'd6, 5'd15, 12'd2101, '0);
		send_item(cdi_pkg::OP_SET, 4'd4, 5'd0, 12'd2000, '0);
		send_item(cdi_pkg::OP_SET, 4'd4, 5'd31, 12'd2000, '0);
		send_item(cdi_pkg::OP_SET, 4'd2, 5'd29, 12'd1900, '0);
		send_item(cdi_pkg::OP_SET, 4'd2, 5'd29, 12'd2000, '0);
		send_item(cdi_pkg::OP_PINC, '0, '0, '0, '0);
		send_item(cdi_pkg::OP_INC, '0, '0, '0, '0);
		send_item(cdi_pkg::OP_SET, 4'd12, 5'd31, 12'd2099, '0);
		send_item(cdi_pkg::OP_INC, '0, '0, '0, '0);
		send_item(cdi_pkg::OP_ADD, '0, '0, '0, 16'd0);
		// From January 1 of a common year, a whole year in one add.
		send_item(cdi_pkg::OP_ADD, '0, '0, '0, 16'd365);
		send_item(cdi_pkg::OP_SET, 4'd12, 5'd31, 12'd2100, '0);
		// About 728,700 days separate the end of 2100 from the ceiling, so
		// the twelfth full-size add runs into it and drops the rest.
		repeat (12) send_item(cdi_pkg::OP_ADD, '0, '0, '0, 16'hFFFF);
		send_item(cdi_pkg::OP_INC, '0, '0, '0, '0);
		send_item(cdi_pkg::OP_PINC, '0, '0, '0, '0);
		send_item(cdi_pkg::OP_ADD, '0, '0, '0, 16'd3);
		send_item(cdi_pkg::OP_ADD, '0, '0, '0, 16'd0);
		send_item(cdi_pkg::OP_SET, 4'd1, 5'd1, 12'd1900, '0);

		repeat (RANDOM_ITEMS) begin
			code = cdi_pkg::OP_W'($urandom_range(0, 3));
			mon  = cdi_pkg::MONTH_W'($urandom);
			dd   = cdi_pkg::DAY_W'($urandom);
			yr   = cdi_pkg::YEAR_W'($urandom);
			cnt  = cdi_pkg::DCNT_W'($urandom);
			pick = $urandom_range(0, 99);
			if (code == cdi_pkg::OP_SET && pick < 80) begin
				// Mostly well-formed dates, often near a month end.
				mon = cdi_pkg::MONTH_W'($urandom_range(1, 12));
				if (pick < 10)
					yr = pick[0] ? cdi_pkg::YEAR_W'(cdi_pkg::MAX_YEAR)
						: cdi_pkg::YEAR_W'(cdi_pkg::MIN_YEAR);
				else
					yr = cdi_pkg::YEAR_W'($urandom_range(cdi_pkg::MIN_YEAR,
						cdi_pkg::MAX_YEAR));
				dd = pick[1] ? cdi_pkg::DAY_W'($urandom_range(28, 31))
					: cdi_pkg::DAY_W'($urandom_range(1, 28));
			end else if (code == cdi_pkg::OP_ADD) begin
				// Keep adds short; only a few take the full count range.
				if (pick < 70) begin
					cnt = cdi_pkg::DCNT_W'($urandom_range(0, 400));
				end else if (pick < 97 || big_adds == 0) begin
					cnt = cdi_pkg::DCNT_W'($urandom_range(401, 3000));
				end else begin
					big_adds--;
				end
			end
			send_item(code, mon, dd, yr, cnt);
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (result_beats < sent_items) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d date beats: %0d sets rejected by range checks,",
			sent_items, rejected_sets);
		$display("%0d beats at the December 31, 4095 ceiling, %0d results checked.",
			overflow_beats, result_beats);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
